### design/rtp_pkg.sv
package rtp_pkg;

	// Widths of the data path and of the beat fields.
	localparam int VAL_W       = 64;
	localparam int LEN_W       = 16;
	localparam int RADIX_W     = 6;
	localparam int COUNT_WIDTH = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 8;
	localparam int PROD_W      = VAL_W + RADIX_W + 1;
	localparam int POS_W       = 33;

	// Decoupling queue between the classifier and the parser.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Bases and digit codes.
	localparam logic [RADIX_W-1:0] BASE_NONE = 6'd0;
	localparam logic [RADIX_W-1:0] BASE_ONE  = 6'd1;
	localparam logic [RADIX_W-1:0] BASE_BIN  = 6'd2;
	localparam logic [RADIX_W-1:0] BASE_OCT  = 6'd8;
	localparam logic [RADIX_W-1:0] BASE_DEC  = 6'd10;
	localparam logic [RADIX_W-1:0] BASE_HEX  = 6'd16;
	localparam logic [RADIX_W-1:0] BASE_MAX  = 6'd36;
	localparam logic [RADIX_W-1:0] DIGIT_NONE    = 6'd63;
	localparam logic [7:0]         LETTER_OFFSET = 8'd10;

	// Saturation values.
	localparam logic [VAL_W-1:0] VAL_ONES  = {VAL_W{1'b1}};
	localparam logic [VAL_W-1:0] VAL_S_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic [VAL_W-1:0] VAL_S_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic [POS_W-1:0] POS_LIM   = (POS_W'(1) << COUNT_WIDTH) - POS_W'(1);
	localparam logic [POS_W-1:0] LEN_LIM   = (POS_W'(1) << LEN_W) - POS_W'(1);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UNSIGNED = 8'd1;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NO_DIGITS = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_BAD_RADIX = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		PH_SPACE,
		PH_START,
		PH_ZERO,
		PH_DIGITS,
		PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] char_code;
		logic       is_last;
	} in_beat_t;

	typedef struct packed {
		logic [VAL_W-1:0] value_bits;
		logic [LEN_W-1:0] consumed_length;
		status_t          status;
	} out_beat_t;

	// Configuration as seen by the parser.
	typedef struct packed {
		logic [RADIX_W-1:0] radix;
		logic               unsigned_mode;
	} cfg_t;

	// A character after classification.
	typedef struct packed {
		logic [RADIX_W-1:0] dval;
		logic               is_space;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               is_b;
		logic               is_o;
		logic               last;
	} cls_t;

	// Queue handshake seen from either end.
	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

endpackage

### design/rtp_front.sv
module rtp_front
	import rtp_pkg::*;
(
	input  logic     in_valid,
	output logic     in_stall,
	input  in_beat_t in_data,
	input  q_stat_t  q_stat,
	output logic     push,
	output cls_t     push_data
);

	logic [7:0] c;
	logic [7:0] lc;

	assign c  = in_data.char_code;
	assign lc = c | 8'h20;

	// The queue takes a beat whenever it has room.
	assign in_stall = q_stat.full;
	assign push     = in_valid && !in_stall;

	// Digit value: decimal digits, then letters of either case.
	always_comb begin
		if (c >= 8'h30 && c <= 8'h39) begin
			push_data.dval = RADIX_W'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h5A) begin
			push_data.dval = RADIX_W'(c - 8'h41 + LETTER_OFFSET);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			push_data.dval = RADIX_W'(c - 8'h61 + LETTER_OFFSET);
		end else begin
			push_data.dval = DIGIT_NONE;
		end

		// Character classes used by the sign and prefix logic.
		push_data.is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
		push_data.is_plus  = (c == 8'h2B);
		push_data.is_minus = (c == 8'h2D);
		push_data.is_zero  = (c == 8'h30);
		push_data.is_x     = (lc == 8'h78);
		push_data.is_b     = (lc == 8'h62);
		push_data.is_o     = (lc == 8'h6F);
		push_data.last     = in_data.is_last;
	end

endmodule

### design/rtp_queue.sv
module rtp_queue
	import rtp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cls_t    push_data,
	input  logic    pop,
	output cls_t    head,
	output q_stat_t q_stat
);

	cls_t              mem_q [QDEPTH];
	cls_t              head_q;
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] rd_next;
	logic              bypass;

	assign head         = head_q;
	assign q_stat.valid = (count_q != '0);
	assign q_stat.full  = (count_q == QCNT_W'(QDEPTH));

	// The head register follows the read pointer; a push into a queue that
	// is empty after this edge goes straight to it.
	assign rd_next = pop ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
	assign bypass  = push && (count_q == QCNT_W'(pop));

	// Entry storage and the registered head.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
		if (bypass) begin
			head_q <= push_data;
		end else begin
			head_q <= mem_q[rd_next];
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QDEPTH))
		else $error("queue count above depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + QCNT_W'(1))
		else $error("push without pop did not grow the queue");
`endif

endmodule

### design/rtp_back.sv
module rtp_back
	import rtp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  q_stat_t   q_stat,
	input  cls_t      item,
	output logic      pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data
);

	// Parse state.
	phase_t             phase_q;
	logic [RADIX_W-1:0] ab_q;
	logic [VAL_W-1:0]   acc_q;
	logic               neg_q;
	logic               ovf_q;
	logic               seen_q;
	logic [COUNT_WIDTH-1:0] pos_q;

	// Result register.
	logic               out_valid_q;
	logic [VAL_W-1:0]   res_acc_q;
	logic               res_neg_q;
	logic               res_uns_q;
	status_t            res_status_q;
	logic [LEN_W-1:0]   res_len_q;

	// Step decode.
	phase_t             ph_step;
	logic [RADIX_W-1:0] ab_step;
	logic               neg_step;
	logic               take;
	logic               seen_force;
	logic [1:0]         bump;
	logic               r_bad;
	logic               r_pfx;
	logic [RADIX_W-1:0] nb;
	logic [RADIX_W-1:0] ab_res;
	logic [RADIX_W-1:0] take_base;
	logic               dig_ok;
	logic [PROD_W-1:0]  prod;
	logic [VAL_W-1:0]   limit;

	// Step data.
	phase_t             phase_d;
	logic [VAL_W-1:0]   acc_step;
	logic               ovf_step;
	logic               seen_step;
	logic               zero_end;
	logic [RADIX_W-1:0] ab_fin;
	logic               seen_fin;
	logic [1:0]         bump_fin;
	logic [POS_W-1:0]   pos_sum;
	logic [COUNT_WIDTH-1:0] pos_next;
	logic               invalid;
	status_t            status_fin;
	logic [LEN_W-1:0]   len_fin;

	// A string end needs room in the result register; other beats never wait.
	assign pop = q_stat.valid && (!item.last || !out_valid_q || !out_stall);

	assign r_bad  = (cfg.radix == BASE_ONE) || (cfg.radix > BASE_MAX);
	assign r_pfx  = (cfg.radix == BASE_HEX) || (cfg.radix == BASE_BIN && !cfg.unsigned_mode);
	assign ab_res = (ab_q == BASE_NONE) ? BASE_OCT : ab_q;

	// Base chosen by the prefix letter after a leading zero.
	always_comb begin
		nb = BASE_NONE;
		if (ab_q == BASE_NONE) begin
			if (item.is_x) begin
				nb = BASE_HEX;
			end else if (item.is_b) begin
				nb = BASE_BIN;
			end else if (item.is_o && !cfg.unsigned_mode) begin
				nb = BASE_OCT;
			end
		end else if (ab_q == BASE_HEX) begin
			if (item.is_x) begin
				nb = BASE_HEX;
			end
		end else if (item.is_b) begin
			nb = BASE_BIN;
		end
	end

	// Base for a digit taken in this beat.
	always_comb begin
		unique case (phase_q)
			PH_SPACE, PH_START: begin
				take_base = (cfg.radix == BASE_NONE) ? BASE_DEC : cfg.radix;
			end
			PH_ZERO: take_base = ab_res;
			default: take_base = ab_q;
		endcase
	end

	// Multiply-add and overflow check against the magnitude limit.
	assign dig_ok = item.dval < take_base;
	assign prod   = PROD_W'(acc_q) * PROD_W'(take_base) + PROD_W'(item.dval);
	assign limit  = cfg.unsigned_mode ? VAL_ONES : (neg_q ? VAL_S_MIN : VAL_S_MAX);

	// Decode of one character against the current phase.
	always_comb begin
		ph_step    = phase_q;
		ab_step    = ab_q;
		neg_step   = neg_q;
		take       = 1'b0;
		seen_force = 1'b0;
		bump       = 2'd0;
		unique case (phase_q)
			PH_SPACE, PH_START: begin
				priority if (phase_q == PH_SPACE && item.is_space) begin
					bump = 2'd1;
				end else if (phase_q == PH_SPACE && (item.is_plus || item.is_minus)) begin
					neg_step = item.is_minus;
					bump     = 2'd1;
					ph_step  = PH_START;
				end else if (cfg.radix == BASE_NONE) begin
					if (item.is_zero) begin
						ab_step = BASE_NONE;
						ph_step = PH_ZERO;
					end else begin
						ab_step = BASE_DEC;
						take    = 1'b1;
					end
				end else if (r_bad) begin
					ab_step = cfg.radix;
					ph_step = PH_DONE;
				end else if (r_pfx && item.is_zero) begin
					ab_step = cfg.radix;
					ph_step = PH_ZERO;
				end else begin
					ab_step = cfg.radix;
					take    = 1'b1;
				end
			end
			PH_ZERO: begin
				if (nb != BASE_NONE) begin
					ab_step = nb;
					ph_step = PH_DIGITS;
					bump    = 2'd2;
				end else begin
					ab_step    = ab_res;
					seen_force = 1'b1;
					bump       = 2'd1;
					take       = 1'b1;
				end
			end
			PH_DIGITS: take = 1'b1;
			default: begin
			end
		endcase
		if (take) begin
			if (dig_ok) begin
				ph_step = PH_DIGITS;
				bump    = bump + 2'd1;
			end else begin
				ph_step = PH_DONE;
			end
		end
	end

	// Next phase: a string end returns to whitespace skip.
	always_comb begin
		if (pop) begin
			phase_d = item.last ? PH_SPACE : ph_step;
		end else begin
			phase_d = phase_q;
		end
	end

	// Data path: accumulator, counters and the finished result.
	always_comb begin
		acc_step  = acc_q;
		ovf_step  = ovf_q;
		seen_step = seen_q || seen_force;
		if (take && dig_ok) begin
			seen_step = 1'b1;
			if (ovf_q || prod > PROD_W'(limit)) begin
				ovf_step = 1'b1;
			end else begin
				acc_step = prod[VAL_W-1:0];
			end
		end
		// A zero still waiting for its prefix letter counts as a digit.
		zero_end = item.last && (ph_step == PH_ZERO);
		ab_fin   = zero_end ? ((ab_step == BASE_NONE) ? BASE_OCT : ab_step) : ab_step;
		seen_fin = seen_step || zero_end;
		bump_fin = bump + {1'b0, zero_end};
		pos_sum  = POS_W'(pos_q) + POS_W'(bump_fin);
		pos_next = (pos_sum > POS_LIM) ? POS_LIM[COUNT_WIDTH-1:0] : pos_sum[COUNT_WIDTH-1:0];
		if (ph_step == PH_SPACE || ph_step == PH_START) begin
			invalid = r_bad;
		end else begin
			invalid = (ab_fin == BASE_ONE) || (ab_fin > BASE_MAX);
		end
		priority if (invalid) begin
			status_fin = ST_BAD_RADIX;
		end else if (!seen_fin) begin
			status_fin = ST_NO_DIGITS;
		end else if (ovf_step) begin
			status_fin = ST_OVERFLOW;
		end else begin
			status_fin = ST_OK;
		end
		if (status_fin == ST_OK || status_fin == ST_OVERFLOW) begin
			len_fin = (POS_W'(pos_next) > LEN_LIM) ? LEN_LIM[LEN_W-1:0]
				: LEN_W'(POS_W'(pos_next));
		end else begin
			len_fin = '0;
		end
	end

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			ab_q    <= BASE_NONE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
			pos_q   <= '0;
		end else begin
			phase_q <= phase_d;
			if (pop) begin
				if (item.last) begin
					ab_q   <= BASE_NONE;
					acc_q  <= '0;
					neg_q  <= 1'b0;
					ovf_q  <= 1'b0;
					seen_q <= 1'b0;
					pos_q  <= '0;
				end else begin
					ab_q   <= ab_step;
					acc_q  <= acc_step;
					neg_q  <= neg_step;
					ovf_q  <= ovf_step;
					seen_q <= seen_step;
					pos_q  <= pos_next;
				end
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && item.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			res_acc_q    <= acc_step;
			res_neg_q    <= neg_step;
			res_uns_q    <= cfg.unsigned_mode;
			res_status_q <= status_fin;
			res_len_q    <= len_fin;
		end
	end

	// Final value: sign applied, the saturation value on overflow, or zero on a failed parse.
	always_comb begin
		out_data.consumed_length = res_len_q;
		out_data.status          = res_status_q;
		unique case (res_status_q)
			ST_OK: begin
				out_data.value_bits = res_neg_q ? (VAL_W'(0) - res_acc_q) : res_acc_q;
			end
			ST_OVERFLOW: begin
				out_data.value_bits = res_uns_q ? VAL_ONES
					: (res_neg_q ? VAL_S_MIN : VAL_S_MAX);
			end
			default: out_data.value_bits = '0;
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_digits_base: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DIGITS |-> (ab_q >= BASE_BIN && ab_q <= BASE_MAX))
		else $error("digit phase with a base outside 2 to 36");
	a_zero_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_ZERO |-> (acc_q == '0 && !seen_q && !ovf_q))
		else $error("prefix phase with digits already taken");
	a_end_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> (phase_q == PH_SPACE && out_valid_q && pos_q == '0))
		else $error("string end did not produce a result and restart");
	a_no_len_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (res_status_q == ST_NO_DIGITS || res_status_q == ST_BAD_RADIX))
		|-> res_len_q == '0)
		else $error("failed parse reports a length");
`endif

endmodule

### design/radix_integer_text_parser_top.sv
// Channel  Handshake            Beat
// in       in_valid / in_stall   in_data: char_code, is_last
// out      out_valid / out_stall out_data: value_bits, consumed_length, status
// cfg      cfg_valid / cfg_ready cfg_index, cfg_data (0 radix, 1 unsigned_mode)
//
// One character per cycle unless out_stall holds a result; the parser does one multiply-add
// by the base per cycle. A result is shown in the cycle after its string end is taken.
// A four-entry queue parts the classifier from the parser, so in_stall rises only when it fills.
// A string end waits in the queue while an earlier result is stalled at the output.
// Reset restores radix 10, signed mode and the whitespace skip phase; no clearing pass.
module radix_integer_text_parser_top
	import rtp_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t    cfg_q;
	q_stat_t q_stat;
	logic    push;
	cls_t    push_data;
	logic    pop;
	cls_t    head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radix         <= BASE_DEC;
			cfg_q.unsigned_mode <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_RADIX:    cfg_q.radix <= cfg_data[RADIX_W-1:0];
				CFG_UNSIGNED: cfg_q.unsigned_mode <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	rtp_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	rtp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	rtp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_stat    (q_stat),
		.item      (head),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule
